// File: hdl/ptr_pkg.sv
`timescale 1ns / 1ps

package ptr_pkg;

	localparam int PALETTE_DEPTH = 64;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int TILE_WIDTH    = 8;
	localparam int COL_W         = $clog2(TILE_WIDTH);

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH      = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT     = 2'd1;
	localparam logic [1:0] REG_TRANSPARENT_ZERO = 2'd2;

	// request opcodes
	localparam logic OP_PALETTE_LOAD = 1'b0;
	localparam logic OP_DRAW_ROW     = 1'b1;

	// colour code that may be transparent
	localparam logic [1:0] CODE_BACKDROP = 2'd0;

	// one column leaving the row sequencer
	typedef struct packed {
		logic [1:0]        code;
		logic [PAL_AW-1:0] pal_idx;
		logic [15:0]       tile_x;
		logic [15:0]       tile_y;
		logic [2:0]        row;
		logic [COL_W-1:0]  col;
		logic              last;
	} col_t;

	// one pixel after palette read and coordinate sums
	typedef struct packed {
		logic [23:0] rgb;
		logic [1:0]  code;
		logic [16:0] px;
		logic [16:0] py;
		logic        last;
	} pix_t;

	// palette index for a colour code, code 0 sits in the top byte
	function automatic logic [PAL_AW-1:0] pick_index(input logic [31:0] set,
		input logic [1:0] code);
		logic [PAL_AW-1:0] idx;
		case (code)
			2'd0: idx = set[24 +: PAL_AW];
			2'd1: idx = set[16 +: PAL_AW];
			2'd2: idx = set[8 +: PAL_AW];
			default: idx = set[0 +: PAL_AW];
		endcase
		return idx;
	endfunction

endpackage

// File: hdl/ptr_row_seq.sv
`timescale 1ns / 1ps

module ptr_row_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ld,
	input  logic [7:0]          plane_low,
	input  logic [7:0]          plane_high,
	input  logic [31:0]         color_set,
	input  logic [15:0]         tile_x,
	input  logic [15:0]         tile_y,
	input  logic [2:0]          row_index,
	input  logic                nxt_rdy,
	output logic                free,
	output logic                col_valid,
	output ptr_pkg::col_t       col_out
);

	localparam logic [ptr_pkg::COL_W-1:0] LAST_COL = ptr_pkg::COL_W'(ptr_pkg::TILE_WIDTH - 1);

	logic                      valid_s1;
	logic [ptr_pkg::COL_W-1:0] col_q;
	logic [7:0]                plane_low_s1;
	logic [7:0]                plane_high_s1;
	logic [31:0]               color_set_s1;
	logic [15:0]               tile_x_s1;
	logic [15:0]               tile_y_s1;
	logic [2:0]                row_s1;

	logic                      issue;
	logic                      last;
	logic [ptr_pkg::COL_W-1:0] bit_sel;
	logic [1:0]                code;

	assign issue   = valid_s1 && nxt_rdy;
	assign last    = (col_q == LAST_COL);
	assign free    = !valid_s1 || (issue && last);
	// bit 7 is the leftmost column
	assign bit_sel = LAST_COL - col_q;
	assign code    = {plane_high_s1[bit_sel], plane_low_s1[bit_sel]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
		end else if (ld) begin
			valid_s1 <= 1'b1;
			col_q    <= '0;
		end else if (issue) begin
			if (last) begin
				valid_s1 <= 1'b0;
			end
			col_q <= col_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			plane_low_s1  <= plane_low;
			plane_high_s1 <= plane_high;
			color_set_s1  <= color_set;
			tile_x_s1     <= tile_x;
			tile_y_s1     <= tile_y;
			row_s1        <= row_index;
		end
	end

	always_comb begin
		col_out.code    = code;
		col_out.pal_idx = ptr_pkg::pick_index(color_set_s1, code);
		col_out.tile_x  = tile_x_s1;
		col_out.tile_y  = tile_y_s1;
		col_out.row     = row_s1;
		col_out.col     = col_q;
		col_out.last    = last;
	end

	assign col_valid = valid_s1;

	a_ld_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> free)
		else $error("row loaded while previous row still issuing");

	a_col_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !issue && !ld) |=> $stable(col_q))
		else $error("column counter moved without issue");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && last && !ld) |=> !valid_s1)
		else $error("row still valid after last column");

endmodule

// File: hdl/ptr_pal_stage.sv
`timescale 1ns / 1ps

module ptr_pal_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [ptr_pkg::PAL_AW-1:0]  wr_slot,
	input  logic [23:0]                 wr_rgb,
	input  logic                        col_valid,
	input  ptr_pkg::col_t               col_in,
	input  logic                        nxt_rdy,
	output logic                        rdy,
	output logic                        pix_valid,
	output ptr_pkg::pix_t               pix_out
);

	logic [23:0]   pal_mem [ptr_pkg::PALETTE_DEPTH];
	logic          valid_s2;
	ptr_pkg::pix_t pix_s2;
	logic          take;

	assign rdy  = !valid_s2 || nxt_rdy;
	assign take = col_valid && rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy) begin
			valid_s2 <= col_valid;
		end
	end

	// read sees the old entry when a load lands on the same edge
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pal_mem[wr_slot] <= wr_rgb;
		end
		if (take) begin
			pix_s2.rgb  <= pal_mem[col_in.pal_idx];
			pix_s2.code <= col_in.code;
			pix_s2.px   <= {col_in.tile_x[15], col_in.tile_x} + 17'(col_in.col);
			pix_s2.py   <= {col_in.tile_y[15], col_in.tile_y} + 17'(col_in.row);
			pix_s2.last <= col_in.last;
		end
	end

	assign pix_valid = valid_s2;
	assign pix_out   = pix_s2;

endmodule

// File: hdl/ptr_pix_out.sv
`timescale 1ns / 1ps

module ptr_pix_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	input  ptr_pkg::pix_t      pix_in,
	input  logic [15:0]        image_width,
	input  logic [15:0]        image_height,
	input  logic               transparent_zero,
	input  logic               out_stall,
	output logic               rdy,
	output logic               out_valid,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [31:0]        pixel_color,
	output logic               write_enable,
	output logic               last_pixel
);

	logic               valid_s3;
	logic signed [15:0] x_s3;
	logic signed [15:0] y_s3;
	logic [31:0]        color_s3;
	logic               we_s3;
	logic               last_s3;

	logic take;
	logic x_in;
	logic y_in;
	logic clear;

	assign rdy   = !valid_s3 || !out_stall;
	assign take  = pix_valid && rdy;
	// sums are 17 bit signed, a set sign bit is left of or above the image
	assign x_in  = !pix_in.px[16] && (pix_in.px[15:0] < image_width);
	assign y_in  = !pix_in.py[16] && (pix_in.py[15:0] < image_height);
	assign clear = transparent_zero && (pix_in.code == ptr_pkg::CODE_BACKDROP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy) begin
			valid_s3 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s3     <= pix_in.px[15:0];
			y_s3     <= pix_in.py[15:0];
			color_s3 <= clear ? 32'h0 : {ptr_pkg::ALPHA_OPAQUE, pix_in.rgb};
			we_s3    <= x_in && y_in && !clear;
			last_s3  <= pix_in.last;
		end
	end

	assign out_valid    = valid_s3;
	assign pixel_x      = x_s3;
	assign pixel_y      = y_s3;
	assign pixel_color  = color_s3;
	assign write_enable = we_s3;
	assign last_pixel   = last_s3;

endmodule

// File: hdl/planar_tile_row_render_unit.sv
// planar tile row renderer
// input channel (in_valid / in_stall): one request per accepted edge. op selects a
// palette load (palette_slot, palette_rgb) or a row draw (plane_low, plane_high,
// color_set, tile_x, tile_y, row_index)
// a palette load is written at its accept edge and gives no pixel
// a row draw gives eight pixel requests on the output channel (out_valid /
// out_stall), left to right, last_pixel set on the eighth
// the first pixel of a row passes the row sequencer, the palette stage and the
// output register before it shows on out_valid; one pixel per cycle while out_stall
// is low, and the row sequencer holds a row while its eight columns issue;
// a load or the next row is taken in the same cycle the last column issues
// config port (cfg_we, cfg_index, cfg_data) sets image width, height and the
// transparent-zero mode; write only while no row is in flight
// reset: pipeline empties, width 256, height 240, transparent mode off;
// palette contents are undefined until loaded
// out_stall freezes the output register; upper stages keep filling bubbles,
// then in_stall rises; nothing is dropped or repeated
`timescale 1ns / 1ps

module planar_tile_row_render_unit (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [5:0]         palette_slot,
	input  logic [23:0]        palette_rgb,
	input  logic [7:0]         plane_low,
	input  logic [7:0]         plane_high,
	input  logic [31:0]        color_set,
	input  logic signed [15:0] tile_x,
	input  logic signed [15:0] tile_y,
	input  logic [2:0]         row_index,
	// pixel channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [31:0]        pixel_color,
	output logic               write_enable,
	output logic               last_pixel
);

	// configuration registers
	logic [15:0] image_width_q;
	logic [15:0] image_height_q;
	logic        transparent_zero_q;

	// handshake between stages
	logic          seq_free;
	logic          col_valid;
	ptr_pkg::col_t col;
	logic          pal_rdy;
	logic          pix_valid;
	ptr_pkg::pix_t pix;
	logic          out_rdy;

	logic accept;
	logic draw_ld;
	logic pal_wr;

	assign in_stall = !seq_free;
	assign accept   = in_valid && seq_free;
	assign draw_ld  = accept && (op == ptr_pkg::OP_DRAW_ROW);
	assign pal_wr   = accept && (op == ptr_pkg::OP_PALETTE_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q      <= 16'd256;
			image_height_q     <= 16'd240;
			transparent_zero_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptr_pkg::REG_IMAGE_WIDTH:      image_width_q      <= cfg_data;
				ptr_pkg::REG_IMAGE_HEIGHT:     image_height_q     <= cfg_data;
				ptr_pkg::REG_TRANSPARENT_ZERO: transparent_zero_q <= cfg_data[0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	// stage 1: holds the row, issues one column per cycle while stage 2 is ready
	ptr_row_seq u_row_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (draw_ld),
		.plane_low  (plane_low),
		.plane_high (plane_high),
		.color_set  (color_set),
		.tile_x     (tile_x),
		.tile_y     (tile_y),
		.row_index  (row_index),
		.nxt_rdy    (pal_rdy),
		.free       (seq_free),
		.col_valid  (col_valid),
		.col_out    (col)
	);

	// stage 2: palette read and coordinate sums
	ptr_pal_stage u_pal_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (pal_wr),
		.wr_slot   (palette_slot[ptr_pkg::PAL_AW-1:0]),
		.wr_rgb    (palette_rgb),
		.col_valid (col_valid),
		.col_in    (col),
		.nxt_rdy   (out_rdy),
		.rdy       (pal_rdy),
		.pix_valid (pix_valid),
		.pix_out   (pix)
	);

	// stage 3: clipping, transparency, output register
	ptr_pix_out u_pix_out (
		.clk              (clk),
		.arst_n           (arst_n),
		.pix_valid        (pix_valid),
		.pix_in           (pix),
		.image_width      (image_width_q),
		.image_height     (image_height_q),
		.transparent_zero (transparent_zero_q),
		.out_stall        (out_stall),
		.rdy              (out_rdy),
		.out_valid        (out_valid),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.pixel_color      (pixel_color),
		.write_enable     (write_enable),
		.last_pixel       (last_pixel)
	);

	// a new row starts at its leftmost column
	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		draw_ld |=> (col_valid && (col.col == '0)))
		else $error("row did not start at column zero");

	// palette writes never overtake reads of an earlier row
	a_load_order: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!col_valid || (pal_rdy && col.last)))
		else $error("request taken while row still issuing");

	// a written pixel always carries an opaque colour
	a_opaque_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && write_enable) |-> (pixel_color[31:24] == ptr_pkg::ALPHA_OPAQUE))
		else $error("written pixel without opaque alpha");

endmodule
